/* hw/rtl/ydec_pkg.sv */
// shared types and constants of the detection row decoder
package ydec_pkg;

   localparam int ValueWidth     = 32;
   localparam int CsrIndexWidth  = 2;
   localparam int CsrDataWidth   = 17;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_CLASS_COUNT     = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_BOXES_PER_IMAGE = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_CONF_THRESHOLD  = 2'd2;

   localparam logic [7:0]  ClassCountReset     = 8'd80;
   localparam logic [15:0] BoxesPerImageReset  = 16'd25200;
   localparam logic [16:0] ConfThresholdReset  = 17'd16384;

   localparam logic [16:0] ConfidenceOne = 17'd65536;

   typedef struct packed {
      logic [7:0]         image_index;
      logic [15:0]        box_index;
      logic signed [7:0]  class_label;
      logic signed [31:0] objectness;
      logic signed [31:0] best_score;
      logic               rejected;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] width;
      logic signed [31:0] height;
   } ydec_row_type;

   typedef struct packed {
      logic [7:0]         image_index;
      logic [15:0]        box_index;
      logic signed [7:0]  class_label;
      logic [16:0]        confidence;
      logic signed [15:0] box_x;
      logic signed [15:0] box_y;
      logic signed [15:0] box_width;
      logic signed [15:0] box_height;
   } ydec_result_type;

endpackage

/* hw/rtl/ydec_accum.sv */
// input register, row parser, arg-max and row/image counters
module ydec_accum import ydec_pkg::*; #(
   parameter int MAX_CLASSES = 128,
   parameter int MAX_IMAGES  = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [ValueWidth-1:0] req_value,
   input  logic                         req_frame_start,
   input  logic [7:0]                   class_count,
   input  logic [15:0]                  boxes_per_image,
   input  logic [16:0]                  conf_threshold,
   output logic                         row_valid,
   input  logic                         row_ready,
   output ydec_row_type                 row
);

   localparam int PosWidth = $clog2(MAX_CLASSES + 5);
   localparam logic [7:0] MaxClassCount = 8'(MAX_CLASSES);
   localparam logic [7:0] LastImage     = 8'(MAX_IMAGES - 1);

   logic                         in_valid_ff;
   logic signed [ValueWidth-1:0] in_value_ff;
   logic                         in_frame_ff;

   logic [PosWidth-1:0] pos_ff, pos_in;
   logic [15:0]         row_ff, row_in;
   logic [7:0]          img_ff, img_in;
   logic signed [31:0]  box_ff [4];
   logic signed [31:0]  box_in [4];
   logic signed [31:0]  obj_ff, obj_in;
   logic signed [31:0]  best_ff, best_in;
   logic signed [7:0]   class_ff, class_in;
   logic                rej_ff, rej_in;

   logic                row_valid_ff;
   ydec_row_type        row_ff_data;

   logic [7:0]          eff_count;
   logic [PosWidth-1:0] last_pos;
   logic [PosWidth-1:0] pos;
   logic [15:0]         row_cur;
   logic [7:0]          img_cur;
   logic                row_end;
   logic                row_free;
   logic                go;
   logic [16:0]         row_plus;

   always_comb begin
      eff_count = (class_count > MaxClassCount) ? MaxClassCount : class_count;
      last_pos  = PosWidth'(4) + PosWidth'(eff_count);
      pos       = in_frame_ff ? '0 : pos_ff;
      row_cur   = in_frame_ff ? '0 : row_ff;
      img_cur   = in_frame_ff ? '0 : img_ff;
      row_end   = pos >= last_pos;
      row_free  = !row_valid_ff || row_ready;
      go        = in_valid_ff && (!row_end || row_free);
      req_ready = !in_valid_ff || go;
   end

   // row state update for the word in the input register
   always_comb begin
      box_in   = box_ff;
      obj_in   = obj_ff;
      best_in  = (pos == '0) ? 32'sd0 : best_ff;
      class_in = (pos == '0) ? -8'sd1 : class_ff;
      rej_in   = (pos == '0) ? 1'b0 : rej_ff;
      if (pos < PosWidth'(4)) begin
         box_in[pos[1:0]] = in_value_ff;
      end else if (pos == PosWidth'(4)) begin
         obj_in = in_value_ff;
         rej_in = $signed({in_value_ff[31], in_value_ff}) < $signed({16'b0, conf_threshold});
      end else if (in_value_ff > best_in) begin
         best_in  = in_value_ff;
         class_in = 8'(pos - PosWidth'(5));
      end
   end

   always_comb begin
      row_plus = {1'b0, row_cur} + 17'd1;
      pos_in   = row_end ? '0 : pos + PosWidth'(1);
      row_in   = row_cur;
      img_in   = img_cur;
      if (row_end) begin
         if (row_plus >= {1'b0, boxes_per_image}) begin
            row_in = '0;
            img_in = (img_cur == LastImage) ? 8'd0 : img_cur + 8'd1;
         end else begin
            row_in = row_plus[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_value_ff <= req_value;
         in_frame_ff <= req_frame_start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         row_ff   <= '0;
         img_ff   <= '0;
         best_ff  <= '0;
         class_ff <= -8'sd1;
         rej_ff   <= 1'b0;
      end else if (go) begin
         pos_ff   <= pos_in;
         row_ff   <= row_in;
         img_ff   <= img_in;
         best_ff  <= best_in;
         class_ff <= class_in;
         rej_ff   <= rej_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         box_ff <= box_in;
         obj_ff <= obj_in;
      end
   end

   // snapshot of a finished row
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= 1'b0;
      end else if (row_free) begin
         row_valid_ff <= go && row_end;
      end
      if (go && row_end) begin
         row_ff_data.image_index <= img_cur;
         row_ff_data.box_index   <= row_cur;
         row_ff_data.class_label <= class_in;
         row_ff_data.objectness  <= obj_in;
         row_ff_data.best_score  <= best_in;
         row_ff_data.rejected    <= rej_in;
         row_ff_data.center_x    <= box_in[0];
         row_ff_data.center_y    <= box_in[1];
         row_ff_data.width       <= box_in[2];
         row_ff_data.height      <= box_in[3];
      end
   end

   assign row_valid = row_valid_ff;
   assign row       = row_ff_data;

endmodule

/* hw/rtl/ydec_score.sv */
// confidence product, box conversion, threshold test and result register
module ydec_score import ydec_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            row_valid,
   output logic            row_ready,
   input  ydec_row_type    row,
   input  logic [16:0]     conf_threshold,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output ydec_result_type result
);

   function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
      logic signed [15:0] r;
      if (v > 34'sd32767) begin
         r = 16'sd32767;
      end else if (v < -34'sd32768) begin
         r = -16'sd32768;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   logic                p_valid_ff;
   logic [45:0]         p_conf_ff;
   logic                p_rej_ff;
   ydec_result_type     p_data_ff;

   logic                out_valid_ff;
   ydec_result_type     out_data_ff;

   logic                obj_pos, best_pos;
   logic [61:0]         product;
   logic signed [33:0]  diff_x, diff_y, bias_x, bias_y;
   logic signed [33:0]  wide_w, wide_h, bias_w, bias_h;
   logic signed [15:0]  box_x, box_y, box_w, box_h;
   logic                emit;
   logic                out_free, p_go, p_free;
   ydec_result_type     p_result;

   always_comb begin
      obj_pos  = !row.objectness[31] && (row.objectness != 32'sd0);
      best_pos = !row.best_score[31] && (row.best_score != 32'sd0);
      product  = (obj_pos && best_pos)
                 ? 62'(row.objectness[30:0]) * 62'(row.best_score[30:0]) : 62'd0;

      // truncation toward zero: bias negative values before the shift
      diff_x = {row.center_x[31], row.center_x, 1'b0} - 34'(row.width);
      diff_y = {row.center_y[31], row.center_y, 1'b0} - 34'(row.height);
      bias_x = diff_x + (diff_x[33] ? 34'sd131071 : 34'sd0);
      bias_y = diff_y + (diff_y[33] ? 34'sd131071 : 34'sd0);
      wide_w = 34'(row.width);
      wide_h = 34'(row.height);
      bias_w = wide_w + (wide_w[33] ? 34'sd65535 : 34'sd0);
      bias_h = wide_h + (wide_h[33] ? 34'sd65535 : 34'sd0);
      box_x  = sat16(bias_x >>> 17);
      box_y  = sat16(bias_y >>> 17);
      box_w  = sat16(bias_w >>> 16);
      box_h  = sat16(bias_h >>> 16);
   end

   always_comb begin
      emit      = !p_rej_ff && (p_conf_ff >= {29'b0, conf_threshold});
      out_free  = !out_valid_ff || rsp_ready;
      p_go      = p_valid_ff && (!emit || out_free);
      p_free    = !p_valid_ff || p_go;
      row_ready = p_free;
      p_result  = p_data_ff;
      p_result.confidence = (p_conf_ff > 46'(ConfidenceOne))
                            ? ConfidenceOne : p_conf_ff[16:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (p_free) begin
         p_valid_ff <= row_valid;
      end
      if (row_valid && p_free) begin
         p_conf_ff              <= product[61:16];
         p_rej_ff               <= row.rejected;
         p_data_ff.image_index  <= row.image_index;
         p_data_ff.box_index    <= row.box_index;
         p_data_ff.class_label  <= row.class_label;
         p_data_ff.confidence   <= '0;
         p_data_ff.box_x        <= box_x;
         p_data_ff.box_y        <= box_y;
         p_data_ff.box_width    <= box_w;
         p_data_ff.box_height   <= box_h;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= p_valid_ff && emit;
      end
      if (p_valid_ff && emit && out_free) begin
         out_data_ff <= p_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign result    = out_data_ff;

endmodule

/* hw/rtl/yolo_detection_row_decode.sv */
// Detection row decoder, top level.
// When ready, the req_ channel carries detector output one Q16.16 word per cycle,
// row by row: cx, cy, w, h, objectness, then class_count class scores.
// req_frame_start on a word restarts the image and row counters and makes
// that word the first of a new row. The rsp_ channel gives at most one
// detection per row: indices, best class (-1 when no score is positive),
// saturated confidence and the box in integer pixels.
// Throughput is one word per cycle while req_ready is high; the input
// register, the row state update, the confidence multiplier stage and the
// result register form a short pipeline, through which a detection reaches
// rsp_valid once its row's last word is accepted.
// When the receiver stalls, the result register holds and the stages in
// front keep absorbing words until a second detection and one more
// finished row fill them; only then does req_ready drop.
// Reset empties the pipeline, clears the counters and loads the register
// defaults (80 classes, 25200 rows per image, threshold 0.25).
// The csr_ port writes class_count, boxes_per_image and the confidence threshold.
module yolo_detection_row_decode import ydec_pkg::*; #(
   parameter int MAX_CLASSES = 128,
   parameter int MAX_IMAGES  = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [ValueWidth-1:0] req_value,
   input  logic                         req_frame_start,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [7:0]                   rsp_image_index,
   output logic [15:0]                  rsp_box_index,
   output logic signed [7:0]            rsp_class_label,
   output logic [16:0]                  rsp_confidence,
   output logic signed [15:0]           rsp_box_x,
   output logic signed [15:0]           rsp_box_y,
   output logic signed [15:0]           rsp_box_width,
   output logic signed [15:0]           rsp_box_height,
   input  logic                         csr_write_enable,
   input  logic [CsrIndexWidth-1:0]     csr_index,
   input  logic [CsrDataWidth-1:0]      csr_data
);

   logic [7:0]      class_count_ff;
   logic [15:0]     boxes_per_image_ff;
   logic [16:0]     conf_threshold_ff;

   logic            row_valid;
   logic            row_ready;
   ydec_row_type    row;
   ydec_result_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         class_count_ff     <= ClassCountReset;
         boxes_per_image_ff <= BoxesPerImageReset;
         conf_threshold_ff  <= ConfThresholdReset;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CLASS_COUNT:     class_count_ff     <= csr_data[7:0];
            CSR_BOXES_PER_IMAGE: boxes_per_image_ff <= csr_data[15:0];
            CSR_CONF_THRESHOLD:  conf_threshold_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   ydec_accum #(
      .MAX_CLASSES (MAX_CLASSES),
      .MAX_IMAGES  (MAX_IMAGES)
   ) u_accum (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_value       (req_value),
      .req_frame_start (req_frame_start),
      .class_count     (class_count_ff),
      .boxes_per_image (boxes_per_image_ff),
      .conf_threshold  (conf_threshold_ff),
      .row_valid       (row_valid),
      .row_ready       (row_ready),
      .row             (row)
   );

   ydec_score u_score (
      .clock           (clock),
      .reset           (reset),
      .row_valid       (row_valid),
      .row_ready       (row_ready),
      .row             (row),
      .conf_threshold  (conf_threshold_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .result          (result)
   );

   assign rsp_image_index = result.image_index;
   assign rsp_box_index   = result.box_index;
   assign rsp_class_label = result.class_label;
   assign rsp_confidence  = result.confidence;
   assign rsp_box_x       = result.box_x;
   assign rsp_box_y       = result.box_y;
   assign rsp_box_width   = result.box_width;
   assign rsp_box_height  = result.box_height;

endmodule

/* hw/rtl/ydec_checker.sv */
// port-level checks of the detection row decoder and their bind
module ydec_checker import ydec_pkg::*; (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [7:0]                   rsp_image_index,
   input logic [15:0]                  rsp_box_index,
   input logic signed [7:0]            rsp_class_label,
   input logic [16:0]                  rsp_confidence,
   input logic signed [15:0]           rsp_box_x,
   input logic signed [15:0]           rsp_box_y,
   input logic signed [15:0]           rsp_box_width,
   input logic signed [15:0]           rsp_box_height
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_confidence)
         && $stable(rsp_image_index) && $stable(rsp_box_index)
         && $stable(rsp_class_label) && $stable(rsp_box_x) && $stable(rsp_box_y)
         && $stable(rsp_box_width) && $stable(rsp_box_height))
      else $error("stalled result word changed");

   // pipeline comes out of reset empty and open
   assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_confidence <= ConfidenceOne)
      else $error("confidence above saturation");

   // no positive score means a zero product
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_class_label == -8'sd1 |-> rsp_confidence == 17'd0)
      else $error("classless detection with nonzero confidence");

endmodule

bind yolo_detection_row_decode ydec_checker u_ydec_checker (.*);

/* sim/yolo_detection_row_decode_test.sv */
// self-checking testbench for the detection row decoder
module yolo_detection_row_decode_test import ydec_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MaxClasses = 128;
   localparam int MaxImages  = 256;

   // predicts detections from the accepted words and checks them in order
   class detection_board;
      logic [7:0]  class_count     = ClassCountReset;
      logic [15:0] boxes_per_image = BoxesPerImageReset;
      logic [16:0] threshold       = ConfThresholdReset;

      int unsigned elem_pos;
      int unsigned row_count;
      logic [7:0]  image_count;
      longint      box_word [4];
      longint      objectness;
      longint      best_score;
      int          best_class = -1;
      bit          rejected;

      ydec_result_type pending_detections [$];
      int errors;
      int words_noted;
      int rows_finished;
      int detections_checked;
      bit image_wrapped;

      function void set_register(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] data);
         case (idx)
            CSR_CLASS_COUNT:     class_count = data[7:0];
            CSR_BOXES_PER_IMAGE: boxes_per_image = data[15:0];
            CSR_CONF_THRESHOLD:  threshold = data;
            default: ;
         endcase
      endfunction

      function int unsigned position();
         return elem_pos;
      endfunction

      function int pending();
         return pending_detections.size();
      endfunction

      function logic signed [15:0] clamp16(longint v);
         if (v > 32767) return 16'sh7FFF;
         if (v < -32768) return 16'sh8000;
         return v[15:0];
      endfunction

      function void note_word(logic signed [31:0] value, logic frame_start);
         longint          v;
         longint          conf;
         int unsigned     eff;
         int unsigned     pos;
         ydec_result_type det;
         v = value;
         eff = (class_count > MaxClasses) ? MaxClasses : class_count;
         words_noted++;
         if (frame_start) begin
            elem_pos = 0;
            row_count = 0;
            image_count = '0;
         end
         pos = elem_pos;
         if (pos == 0) begin
            best_score = 0;
            best_class = -1;
            rejected = 1'b0;
         end
         if (pos < 4) begin
            box_word[pos] = v;
         end else if (pos == 4) begin
            objectness = v;
            rejected = v < longint'(threshold);
         end else if (v > best_score) begin
            best_score = v;
            best_class = pos - 5;
         end
         if (pos >= eff + 4) begin
            rows_finished++;
            conf = 0;
            if (objectness > 0 && best_score > 0)
               conf = (objectness * best_score) >>> 16;
            if (!rejected && conf >= longint'(threshold)) begin
               det.image_index = image_count;
               det.box_index   = row_count[15:0];
               det.class_label = best_class[7:0];
               det.confidence  = (conf > longint'(ConfidenceOne)) ? ConfidenceOne : conf[16:0];
               det.box_x       = clamp16((2 * box_word[0] - box_word[2]) / 131072);
               det.box_y       = clamp16((2 * box_word[1] - box_word[3]) / 131072);
               det.box_width   = clamp16(box_word[2] / 65536);
               det.box_height  = clamp16(box_word[3] / 65536);
               pending_detections.insert(pending_detections.size(), det);
            end
            elem_pos = 0;
            if (row_count + 1 >= boxes_per_image) begin
               row_count = 0;
               if (image_count == 8'(MaxImages - 1))
                  image_wrapped = 1'b1;
               image_count = image_count + 8'd1;
            end else begin
               row_count = row_count + 1;
            end
         end else begin
            elem_pos = pos + 1;
         end
      endfunction

      function void compare_field(string name, logic signed [63:0] want,
                                  logic signed [63:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_detection(ydec_result_type got);
         ydec_result_type want;
         if (pending_detections.size() == 0) begin
            errors++;
            $display("%0t: unexpected detection, expected none, actual image %0d box %0d",
                     $time, got.image_index, got.box_index);
            return;
         end
         want = pending_detections.pop_front();
         detections_checked++;
         compare_field("image_index", want.image_index, got.image_index);
         compare_field("box_index", want.box_index, got.box_index);
         compare_field("class_label", want.class_label, got.class_label);
         compare_field("confidence", want.confidence, got.confidence);
         compare_field("box_x", want.box_x, got.box_x);
         compare_field("box_y", want.box_y, got.box_y);
         compare_field("box_width", want.box_width, got.box_width);
         compare_field("box_height", want.box_height, got.box_height);
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic signed [ValueWidth-1:0] req_value = '0;
   logic                         req_frame_start = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [7:0]                   rsp_image_index;
   logic [15:0]                  rsp_box_index;
   logic signed [7:0]            rsp_class_label;
   logic [16:0]                  rsp_confidence;
   logic signed [15:0]           rsp_box_x;
   logic signed [15:0]           rsp_box_y;
   logic signed [15:0]           rsp_box_width;
   logic signed [15:0]           rsp_box_height;
   logic                         csr_write_enable = 1'b0;
   logic [CsrIndexWidth-1:0]     csr_index = CSR_CLASS_COUNT;
   logic [CsrDataWidth-1:0]      csr_data = '0;

   ydec_result_type    rsp_detection;
   detection_board     board;
   int                 words_sent;
   logic signed [31:0] last_score;

   yolo_detection_row_decode #(
      .MAX_CLASSES(MaxClasses),
      .MAX_IMAGES (MaxImages)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_value       (req_value),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_image_index (rsp_image_index),
      .rsp_box_index   (rsp_box_index),
      .rsp_class_label (rsp_class_label),
      .rsp_confidence  (rsp_confidence),
      .rsp_box_x       (rsp_box_x),
      .rsp_box_y       (rsp_box_y),
      .rsp_box_width   (rsp_box_width),
      .rsp_box_height  (rsp_box_height),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver stalls a lot early, the sender idles a lot in the middle, nobody at the end
   function automatic int sender_idle_percent();
      if (words_sent < 600) return 12;
      if (words_sent < 1200) return 48;
      return 0;
   endfunction

   function automatic int receiver_stall_percent();
      if (words_sent < 600) return 48;
      if (words_sent < 1200) return 12;
      return 0;
   endfunction

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_percent());
   end

   assign rsp_detection = '{rsp_image_index, rsp_box_index, rsp_class_label, rsp_confidence,
                            rsp_box_x, rsp_box_y, rsp_box_width, rsp_box_height};

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         board.check_detection(rsp_detection);
   end

   function automatic int span(int lo, int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // word content shaped by its place in the row
   function automatic logic signed [31:0] pick_value(int unsigned pos);
      int unsigned        r;
      logic signed [31:0] v;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         case ($urandom_range(0, 3))
            0: v = 32'sh7FFF_FFFF;
            1: v = 32'sh8000_0000;
            2: v = '0;
            default: v = '1;
         endcase
      end else if (r < 22) begin
         v = $urandom;
      end else if (pos < 4) begin
         v = (span(-700, 700) <<< 16) + int'($urandom_range(0, 65535));
      end else if (pos == 4) begin
         if (r < 40) v = board.threshold;
         else if (r < 50) v = span(-65536, -1);
         else v = span(0, 3 * 65536);
      end else begin
         if (r < 40) v = last_score;
         else if (r < 50) v = span(-65536, 0);
         else if (r < 80) v = span(0, 65536);
         else v = span(0, 4 * 65536);
      end
      if (pos > 4)
         last_score = v;
      return v;
   endfunction

   task automatic send_word(logic signed [31:0] value, logic frame_start);
      while ($urandom_range(0, 99) < sender_idle_percent()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_value       <= value;
      req_frame_start <= frame_start;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      board.note_word(value, frame_start);
      words_sent++;
   endtask

   // hold off until every pending detection is out and the pipeline is empty
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= data;
      @(posedge clock);
      board.set_register(idx, data);
   endtask

   // unused upper data bits carry junk
   task automatic program_registers(logic [7:0] cc, logic [15:0] bpi, logic [16:0] thr);
      logic [31:0] junk;
      junk = $urandom;
      write_csr(CSR_CLASS_COUNT, {junk[8:0], cc});
      write_csr(CSR_BOXES_PER_IMAGE, {junk[9], bpi});
      write_csr(CSR_CONF_THRESHOLD, thr);
      csr_write_enable <= 1'b0;
   endtask

   task automatic stream_words(int count, bit noisy);
      logic frame_start;
      for (int i = 0; i < count; i++) begin
         frame_start = noisy && ($urandom_range(0, 39) == 0);
         send_word(pick_value(frame_start ? 0 : board.position()), frame_start);
      end
   endtask

   initial begin
      logic signed [31:0] directed_words [24];
      logic [7:0]         cc;
      logic [15:0]        bpi;
      logic [16:0]        thr;
      int                 r;

      board = new;
      directed_words = '{
         // tied scores, negative height
         32'sh0064_8000, 32'sh0032_4000, 32'sh0028_C000, 32'shFFE1_8000,
         32'sh0001_0000, 32'sh0000_8000, 32'sh0000_8000,
         // extremes everywhere, saturating box and confidence
         32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
         32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
         // partial row, dropped by the frame start that follows
         32'sh0000_0001, 32'shFFFF_FFFF, 32'sh0001_0000,
         // objectness one below the default threshold
         32'sh0010_0000, 32'sh0020_0000, 32'sh0004_0000, 32'sh0004_0000,
         32'sh0000_3FFF, 32'sh0001_0000, 32'sh0002_0000
      };
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // threshold left at its reset value here
      write_csr(CSR_CLASS_COUNT, 17'd2);
      write_csr(CSR_BOXES_PER_IMAGE, 17'd2);
      csr_write_enable <= 1'b0;
      for (int i = 0; i < 24; i++)
         send_word(directed_words[i], i == 0 || i == 17);
      settle();

      program_registers(8'd0, 16'd0, 17'd0);
      stream_words(40, 1'b0);
      settle();
      program_registers(8'd1, 16'd1, ConfidenceOne);
      stream_words(20, 1'b0);
      settle();
      // widest rows, left open so the next count applies mid-row
      program_registers(8'(MaxClasses), 16'hFFFF, 17'($urandom_range(0, 65536)));
      stream_words(140, 1'b0);
      settle();
      program_registers(8'hFF, 16'd2, 17'h1FFFF);
      stream_words(134, 1'b0);
      settle();
      program_registers(ClassCountReset, BoxesPerImageReset, ConfThresholdReset);
      stream_words(86, 1'b0);
      settle();

      // short rows, one image each, until the image index wraps
      program_registers(8'd0, 16'd0, 17'd0);
      while (!board.image_wrapped)
         send_word(pick_value(board.position()), 1'b0);
      stream_words(10, 1'b0);
      settle();

      for (int p = 0; p < 4; p++) begin
         r = $urandom_range(0, 99);
         if (r < 15) cc = 8'd0;
         else if (r < 75) cc = 8'($urandom_range(1, 4));
         else if (r < 92) cc = 8'($urandom_range(5, 16));
         else cc = 8'($urandom_range(17, 40));
         bpi = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
         r = $urandom_range(0, 99);
         if (r < 20) thr = 17'd0;
         else if (r < 60) thr = 17'($urandom_range(1, 32768));
         else if (r < 75) thr = ConfidenceOne;
         else if (r < 90) thr = 17'($urandom_range(65537, 131071));
         else thr = 17'($urandom_range(0, 131071));
         program_registers(cc, bpi, thr);
         stream_words($urandom_range(12, 40), 1'b1);
         settle();
      end

      $display("%0d words streamed, %0d rows closed, %0d detections checked",
               board.words_noted, board.rows_finished, board.detections_checked);
      $display("image index wrapped: %0d, mismatches: %0d", board.image_wrapped, board.errors);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #4_800_000;
      $display("timeout with %0d detections outstanding", board.pending());
      $display("Regression FAIL");
      $finish;
   end

endmodule

/* yolo_detection_row_decode.f */
hw/rtl/ydec_pkg.sv
hw/rtl/ydec_accum.sv
hw/rtl/ydec_score.sv
hw/rtl/yolo_detection_row_decode.sv
hw/rtl/ydec_checker.sv
sim/yolo_detection_row_decode_test.sv
